// ===== rtl/ibsr_pkg.sv =====
// Shared types and constants for the bright speck removal block.
`timescale 1ns / 1ps

package ibsr_pkg;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;

    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    // Speck test thresholds on the red channel.
    localparam logic [7:0] LOW_LIMIT  = 8'd127;
    localparam logic [7:0] HIGH_LIMIT = 8'd128;

    // Divide by three: (sum * 171) >> 9 is exact for sums below 512.
    localparam logic [8:0] THIRD_MULT  = 9'd171;
    localparam int         THIRD_SHIFT = 9;

    // Counted items before the pass-one stream has a finished pixel.
    localparam logic [1:0] PRIME_COUNT = 2'd2;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Two rows of pass-one pixels at one column.
    typedef struct packed {
        rgb_t newer;
        rgb_t older;
    } rgb_pair_t;

    // Two rows of pass-two red at one column.
    typedef struct packed {
        logic [7:0] newer;
        logic [7:0] older;
    } red_pair_t;

endpackage

// ===== rtl/ibsr_pix_in_if.sv =====
// Input pixel channel: valid/ready handshake with RGB and filler payload.
`timescale 1ns / 1ps

interface ibsr_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       filler;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output filler, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input filler, output ready);
endinterface

// ===== rtl/ibsr_pix_out_if.sv =====
// Output pixel channel: valid/ready handshake with RGB and frame_last payload.
`timescale 1ns / 1ps

interface ibsr_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_last, output ready);
endinterface

// ===== rtl/ibsr_despeck.sv =====
// Five-tap speck test and replacement on red values.
`timescale 1ns / 1ps

module ibsr_despeck
(
    input  logic [7:0] c0,
    input  logic [7:0] c1,
    input  logic [7:0] c2,
    input  logic [7:0] c3,
    input  logic [7:0] c4,
    output logic [7:0] result
);
    import ibsr_pkg::*;

    logic        lead_hit;
    logic        trail_hit;
    logic [8:0]  sum;
    logic [17:0] product;

    always_comb
    begin
        lead_hit  = (c0 < LOW_LIMIT) && (c1 < LOW_LIMIT) && (c2 > HIGH_LIMIT)
                    && (c3 < LOW_LIMIT);
        trail_hit = (c1 < LOW_LIMIT) && (c2 > HIGH_LIMIT) && (c3 < LOW_LIMIT)
                    && (c4 < LOW_LIMIT);
        if (lead_hit)
        begin
            sum = 9'(c0) + 9'(c1) + 9'(c3);
        end
        else
        begin
            sum = 9'(c1) + 9'(c3) + 9'(c4);
        end
        product = 18'(sum) * 18'(THIRD_MULT);
        result  = (lead_hit || trail_hit) ? product[THIRD_SHIFT +: 8] : c2;
    end

endmodule

// ===== rtl/isolated_bright_speck_removal_core.sv =====
// Top level of the bright speck removal block: window, line stores, output stage.
`timescale 1ns / 1ps

// Usage
// Pixels enter on "pixels" in raster order, one transfer per pixel; filtered
// pixels leave on "filtered" in the same order. Results lag the input by
// 2*W+2 counted items, so after the last pixel of a frame send 2*W+2 filler
// items to drain it; frame_last marks the final pixel out. Fillers that come
// before a frame is complete are taken and dropped.
// Throughput is one item per cycle while the receiver keeps up. The
// transfer of the item that completes a result loads the middle stage
// (row window and line store read); the middle stage then loads the output
// register through the column test once the output register is free.
// When the receiver stalls, one more item is taken into the middle stage,
// then ready drops until the output register is drained.
// Reset (and any configuration write) restarts the frame counters; width and
// height reset to 640 x 480. Write frame_width / frame_height only while idle.
// The line stores need no clearing: no entry is used before it is written.

module isolated_bright_speck_removal_core
#(
    parameter int MAX_WIDTH  = ibsr_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = ibsr_pkg::DEFAULT_MAX_HEIGHT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  ibsr_pkg::cfg_index_t             cfg_index,
    input  logic [ibsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    ibsr_pix_in_if.sink                      pixels,
    ibsr_pix_out_if.source                   filtered
);
    import ibsr_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PRW = $clog2(MAX_HEIGHT + 2);

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [CW-1:0]             w_eff;
    logic [HW-1:0]             h_eff;

    logic [AW-1:0]  in_col_reg;
    logic [HW-1:0]  in_row_reg;
    logic [1:0]     warm_reg;
    logic [AW-1:0]  pcol_reg;
    logic [PRW-1:0] prow_reg;

    rgb_t win_reg [5];

    logic      accept;
    logic      in_frame;
    logic      counted;
    logic      p_make;
    rgb_t      in_pix;
    logic      visit;
    logic [7:0] h_val;
    rgb_t      p_pix;
    logic      p_last;
    logic      p_emit;
    logic      p_vert;

    rgb_pair_t first_rows_mem [MAX_WIDTH];
    red_pair_t second_rows_mem [MAX_WIDTH];
    rgb_pair_t m_rd_reg;
    red_pair_t s_rd_reg;
    rgb_pair_t m_wr;
    red_pair_t s_wr;

    logic          s1_valid_reg;
    logic          s1_emit_reg;
    logic          s1_vert_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s1_x_reg;
    rgb_t          s1_p_reg;
    logic          s1_go;
    logic [7:0]    v_val;
    rgb_t          s1_result;

    logic out_valid_reg;
    logic out_valid_next;
    rgb_t out_pix_reg;
    logic out_last_reg;
    logic out_free;

    // Clamp the frame size registers to the supported range.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(frame_width_reg);
        end

        if (frame_height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(frame_height_reg);
        end
    end

    assign out_free      = !out_valid_reg || filtered.ready;
    assign s1_go         = s1_valid_reg && (!s1_emit_reg || out_free);
    assign pixels.ready  = !s1_valid_reg || s1_go;
    assign accept        = pixels.valid && pixels.ready;
    assign in_frame      = in_row_reg < h_eff;
    assign counted       = accept && !(in_frame && pixels.filler);
    assign p_make        = counted && (warm_reg == PRIME_COUNT);
    assign in_pix        = rgb_t'{red: pixels.red_in, green: pixels.green_in,
                                  blue: pixels.blue_in};

    // Row pass: centre of the window is the pixel two columns back.
    assign visit = (pcol_reg >= AW'(2)) && (32'(pcol_reg) + 32'd3 <= 32'(w_eff));

    ibsr_despeck u_row_despeck
    (
        .c0     (win_reg[1].red),
        .c1     (win_reg[2].red),
        .c2     (win_reg[3].red),
        .c3     (win_reg[4].red),
        .c4     (in_pix.red),
        .result (h_val)
    );

    assign p_pix  = visit ? rgb_t'{red: h_val, green: h_val, blue: h_val} : win_reg[3];
    assign p_last = (32'(prow_reg) == 32'(h_eff) + 32'd1)
                    && (32'(pcol_reg) + 32'd1 == 32'(w_eff));
    assign p_emit = prow_reg >= PRW'(2);
    assign p_vert = (prow_reg >= PRW'(4)) && (32'(prow_reg) < 32'(h_eff));

    always_ff @(posedge clk)
    begin
        if (counted)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= p_pix;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= in_pix;
        end
    end

    // Configuration and frame position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_W'(RESET_FRAME_WIDTH);
            frame_height_reg <= FRAME_HEIGHT_W'(RESET_FRAME_HEIGHT);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            warm_reg         <= '0;
            pcol_reg         <= '0;
            prow_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
            in_col_reg <= '0;
            in_row_reg <= '0;
            warm_reg   <= '0;
            pcol_reg   <= '0;
            prow_reg   <= '0;
        end
        else if (p_make && p_last)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            warm_reg   <= '0;
            pcol_reg   <= '0;
            prow_reg   <= '0;
        end
        else
        begin
            if (counted && in_frame)
            begin
                if (32'(in_col_reg) + 32'd1 >= 32'(w_eff))
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + HW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + AW'(1);
                end
            end
            if (counted && (warm_reg != PRIME_COUNT))
            begin
                warm_reg <= warm_reg + 2'd1;
            end
            if (p_make)
            begin
                if (32'(pcol_reg) + 32'd1 >= 32'(w_eff))
                begin
                    pcol_reg <= '0;
                    prow_reg <= prow_reg + PRW'(1);
                end
                else
                begin
                    pcol_reg <= pcol_reg + AW'(1);
                end
            end
        end
    end

    // Line stores: read for the new item, write back when the middle stage retires.
    // Same-column bypass only happens with a one-pixel row.
    assign m_wr = '{newer: s1_p_reg, older: m_rd_reg.newer};
    assign s_wr = '{newer: s1_result.red, older: s_rd_reg.newer};

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            first_rows_mem[s1_x_reg] <= m_wr;
        end
        if (p_make)
        begin
            if (s1_valid_reg && (s1_x_reg == pcol_reg))
            begin
                m_rd_reg <= m_wr;
            end
            else
            begin
                m_rd_reg <= first_rows_mem[pcol_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            second_rows_mem[s1_x_reg] <= s_wr;
        end
        if (p_make)
        begin
            if (s1_valid_reg && s1_emit_reg && (s1_x_reg == pcol_reg))
            begin
                s_rd_reg <= s_wr;
            end
            else
            begin
                s_rd_reg <= second_rows_mem[pcol_reg];
            end
        end
    end

    // Column pass on the output row.
    ibsr_despeck u_col_despeck
    (
        .c0     (s_rd_reg.older),
        .c1     (s_rd_reg.newer),
        .c2     (m_rd_reg.older.red),
        .c3     (m_rd_reg.newer.red),
        .c4     (s1_p_reg.red),
        .result (v_val)
    );

    assign s1_result = s1_vert_reg ? rgb_t'{red: v_val, green: v_val, blue: v_val}
                                   : m_rd_reg.older;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (p_make)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_make)
        begin
            s1_emit_reg <= p_emit;
            s1_vert_reg <= p_vert;
            s1_last_reg <= p_last;
            s1_x_reg    <= pcol_reg;
            s1_p_reg    <= p_pix;
        end
    end

    // Output register.
    always_comb
    begin
        if (s1_go && s1_emit_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (filtered.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            out_pix_reg  <= s1_result;
            out_last_reg <= s1_last_reg;
        end
    end

    assign filtered.valid      = out_valid_reg;
    assign filtered.red_out    = out_pix_reg.red;
    assign filtered.green_out  = out_pix_reg.green;
    assign filtered.blue_out   = out_pix_reg.blue;
    assign filtered.frame_last = out_last_reg;

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_x_reg))
        else $error("middle stage lost a held item");

    a_pcol_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pcol_reg) < 32'(w_eff))
        else $error("output column beyond frame width");

    a_in_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(in_row_reg) <= 32'(h_eff))
        else $error("input row beyond frame height");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the bright speck removal core.
`timescale 1ns / 1ps

module tb;
    import ibsr_pkg::*;

    localparam int MAXW = DEFAULT_MAX_WIDTH;
    localparam int MAXH = DEFAULT_MAX_HEIGHT;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       filler;
    } pix_item_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pix_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ibsr_pix_in_if  pix ();
    ibsr_pix_out_if res ();

    isolated_bright_speck_removal_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pixels   (pix),
        .filtered (res)
    );

    pix_item_t   pending_pixels[$];
    pix_result_t expected_pixels[$];
    int          error_count;
    int          idle_pct;
    int          result_count;
    int          stall_left;
    bit          stall_done;

    // Predictor state
    logic [23:0] row_store [0:5*MAXW-1];
    logic [7:0]  col_store [0:2*MAXW-1];
    int unsigned width_reg, height_reg;
    int unsigned in_col, in_row, item_cnt, out_cnt, out_col, out_row;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int unsigned eff_width();
        if (width_reg < 1) return 1;
        if (width_reg > MAXW) return MAXW;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < 1) return 1;
        if (height_reg > MAXH) return MAXH;
        return height_reg;
    endfunction

    function automatic logic [7:0] despeck(input int unsigned c0, c1, c2, c3, c4);
        if (c0 < LOW_LIMIT && c1 < LOW_LIMIT && c2 > HIGH_LIMIT && c3 < LOW_LIMIT)
            return 8'((c0 + c1 + c3) / 3);
        if (c1 < LOW_LIMIT && c2 > HIGH_LIMIT && c3 < LOW_LIMIT && c4 < LOW_LIMIT)
            return 8'((c1 + c3 + c4) / 3);
        return 8'(c2);
    endfunction

    function automatic int unsigned red_of(input int unsigned slot, col);
        return row_store[slot*MAXW + col][23:16];
    endfunction

    task automatic restart_frame();
        in_col = 0; in_row = 0; item_cnt = 0;
        out_cnt = 0; out_col = 0; out_row = 0;
    endtask

    task automatic predict_pixel(input pix_item_t it);
        int unsigned w, h, slot, c, base, own;
        logic [7:0]  v, r, g, b;
        pix_result_t exp_res;
        w = eff_width();
        h = eff_height();
        if (in_row < h) begin
            if (it.filler)
                return;
            slot = in_row % 5;
            base = slot * MAXW;
            row_store[base + in_col] = {it.red, it.green, it.blue};
            if (in_col >= 4) begin
                c = in_col - 2;
                v = despeck(red_of(slot, c-2), red_of(slot, c-1), red_of(slot, c),
                            red_of(slot, c+1), red_of(slot, c+2));
                row_store[base + c] = {v, v, v};
            end
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        item_cnt++;
        if (item_cnt <= 2*w + 2)
            return;
        own = row_store[(out_row % 5)*MAXW + out_col];
        if (out_row >= 2 && out_row + 2 < h) begin
            v = despeck(col_store[(out_row & 1)*MAXW + out_col],
                        col_store[((out_row + 1) & 1)*MAXW + out_col],
                        own[23:16], red_of((out_row + 1) % 5, out_col),
                        red_of((out_row + 2) % 5, out_col));
            r = v; g = v; b = v;
        end
        else begin
            r = own[23:16]; g = own[15:8]; b = own[7:0];
        end
        col_store[(out_row & 1)*MAXW + out_col] = r;
        out_cnt++;
        exp_res.red   = r;
        exp_res.green = g;
        exp_res.blue  = b;
        exp_res.last  = (out_cnt >= w*h);
        expected_pixels.push_back(exp_res);
        if (exp_res.last)
            restart_frame();
        else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // Input driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pix.valid    <= 1'b0;
            pix.red_in   <= '0;
            pix.green_in <= '0;
            pix.blue_in  <= '0;
            pix.filler   <= 1'b0;
        end
        else begin
            if (pix.valid && pix.ready)
                predict_pixel(pix_item_t'{pix.red_in, pix.green_in, pix.blue_in,
                                          pix.filler});
            if (!pix.valid || pix.ready) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    pix_item_t it;
                    it = pending_pixels.pop_front();
                    pix.valid    <= 1'b1;
                    pix.red_in   <= it.red;
                    pix.green_in <= it.green;
                    pix.blue_in  <= it.blue;
                    pix.filler   <= it.filler;
                end
                else
                    pix.valid <= 1'b0;
            end
        end
    end

    // Output monitor with one long hold-off to back the pipe up
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res.ready    <= 1'b0;
            result_count <= 0;
            stall_left   <= 0;
            stall_done   <= 1'b0;
        end
        else begin
            if (res.valid && res.ready) begin
                result_count <= result_count + 1;
                if (expected_pixels.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else begin
                    pix_result_t e;
                    e = expected_pixels.pop_front();
                    if (res.red_out !== e.red)
                        report_mismatch($sformatf("red %0d exp %0d", res.red_out, e.red));
                    if (res.green_out !== e.green)
                        report_mismatch($sformatf("green %0d exp %0d", res.green_out,
                                                  e.green));
                    if (res.blue_out !== e.blue)
                        report_mismatch($sformatf("blue %0d exp %0d", res.blue_out, e.blue));
                    if (res.frame_last !== e.last)
                        report_mismatch($sformatf("frame_last %0b exp %0b", res.frame_last,
                                                  e.last));
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res.ready  <= 1'b0;
            end
            else if (!stall_done && result_count >= 150) begin
                stall_done <= 1'b1;
                stall_left <= 400;
                res.ready  <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input int unsigned val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        if (idx == CFG_FRAME_WIDTH)
            width_reg = val & 'h7FF;
        else
            height_reg = val & 'h1FFF;
        restart_frame();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_red();
        case ($urandom_range(7))
            0, 1, 2, 3, 4: return 8'($urandom_range(126));
            5:             return 8'($urandom_range(255, 129));
            6:             return 8'($urandom_range(129, 126));
            default:       return 8'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic [7:0] r, input logic f);
        pending_pixels.push_back(pix_item_t'{r, 8'($urandom), 8'($urandom), f});
    endtask

    // Queue one frame; a nonzero cut stops after that many pixels, no flush
    task automatic queue_frame(input int unsigned w, h, cut);
        int unsigned ew, eh, npix;
        ew = (w < 1) ? 1 : (w > MAXW) ? MAXW : w;
        eh = (h < 1) ? 1 : (h > MAXH) ? MAXH : h;
        npix = (cut != 0) ? cut : ew*eh;
        for (int unsigned i = 0; i < npix; i++) begin
            if ($urandom_range(19) == 0)
                push_pixel(pick_red(), 1'b1);   // stray filler, dropped
            push_pixel(pick_red(), 1'b0);
        end
        if (cut == 0)
            for (int unsigned i = 0; i < 2*ew + 2; i++)
                push_pixel(pick_red(), ($urandom_range(5) != 0));
    endtask

    // Sampled at the falling edge, after the driver has settled
    task automatic drain();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || pix.valid);
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_frame(input int unsigned w, h, cut);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        queue_frame(w, h, cut);
        drain();
    endtask

    initial begin
        logic [7:0] directed_red [25];
        int unsigned sent, w, h;
        directed_red = '{50, 200, 50, 0, 255,
                         126, 127, 128, 129, 100,
                         10, 10, 255, 10, 10,
                         0, 129, 0, 0, 0,
                         255, 0, 255, 0, 126};
        error_count = 0;
        idle_pct    = 21;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_FRAME_WIDTH;
        cfg_data    = '0;
        width_reg   = RESET_FRAME_WIDTH;
        height_reg  = RESET_FRAME_HEIGHT;
        restart_frame();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed 5x5 frame with specks, threshold values and extremes
        write_reg(CFG_FRAME_WIDTH, 5);
        write_reg(CFG_FRAME_HEIGHT, 5);
        foreach (directed_red[i]) begin
            if (i == 7)
                push_pixel(8'd255, 1'b1);
            push_pixel(directed_red[i], 1'b0);
        end
        for (int i = 0; i < 12; i++)
            push_pixel(8'd0, (i % 3 != 0));
        drain();

        // Register extremes, including out-of-range values (the oversized ones cut short)
        run_frame(1, 1, 0);
        run_frame(0, 0, 0);
        run_frame(4, 4, 0);
        run_frame(2047, 1, 60);
        run_frame(1, 8191, 60);
        idle_pct = 0;
        run_frame(16, 12, 0);
        run_frame(16, 12, 0);
        idle_pct = 21;

        sent = 0;
        while (sent < 1100) begin
            if ($urandom_range(5) == 0) begin
                w = $urandom_range(4, 1);
                h = $urandom_range(6, 1);
            end
            else begin
                w = $urandom_range(16, 5);
                h = $urandom_range(12, 5);
            end
            if ($urandom_range(7) == 0) begin
                run_frame(w, h, $urandom_range(w*h, 1));
                sent += w*h;
            end
            else begin
                run_frame(w, h, 0);
                sent += w*h + 2*w + 2;
            end
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
